/* design/spt_pkg.sv */
// ----------------------------------------------------------------------------
// spt_pkg
// Shared types and constants for the script push tokenizer.
// ----------------------------------------------------------------------------
package spt_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned LEN_W  = 16;

    // Marker values
    localparam logic [BYTE_W-1:0] MAX_DIRECT = 8'd75;
    localparam logic [BYTE_W-1:0] MARK_LEN8  = 8'd76;
    localparam logic [BYTE_W-1:0] MARK_LEN16 = 8'd77;

    // Parser phase
    typedef enum logic [1:0] {
        PH_MARKER  = 2'd0,
        PH_LEN8    = 2'd1,
        PH_LEN16   = 2'd2,
        PH_PAYLOAD = 2'd3
    } phase_t;

    // Token classification
    typedef enum logic [1:0] {
        TK_OPCODE  = 2'd0,
        TK_HEADER  = 2'd1,
        TK_PAYLOAD = 2'd2
    } token_kind_t;

    // Parser state carried between bytes
    typedef struct packed {
        phase_t             phase;
        logic [LEN_W-1:0]   remaining;
        logic [BYTE_W-1:0]  len_low;
        logic [LEN_W-1:0]   cur_len;
    } parse_state_t;

    // One classified byte
    typedef struct packed {
        token_kind_t        kind;
        logic [BYTE_W-1:0]  value;
        logic               done;
        logic [LEN_W-1:0]   plen;
        logic               trunc;
    } token_t;

    localparam parse_state_t PARSE_RESET = '{
        phase:     PH_MARKER,
        remaining: '0,
        len_low:   '0,
        cur_len:   '0
    };

endpackage

/* design/spt_decode.sv */
// ----------------------------------------------------------------------------
// spt_decode
// Classifies one script byte against the current parser state and produces
// the token fields and the next parser state.
// ----------------------------------------------------------------------------
module spt_decode (
    input  spt_pkg::parse_state_t state,
    input  logic [7:0]            script_byte,
    input  logic                  end_of_script,
    output spt_pkg::parse_state_t state_next,
    output spt_pkg::token_t       token
);
    import spt_pkg::*;

    parse_state_t       st;
    token_t             tk;
    logic [LEN_W-1:0]   len16;
    logic [LEN_W-1:0]   rem_dec;

    assign len16 = {script_byte, state.len_low};

    always_comb
    begin
        st       = state;
        tk.kind  = TK_HEADER;
        tk.value = script_byte;
        tk.done  = 1'b0;
        tk.plen  = '0;
        tk.trunc = 1'b0;
        rem_dec  = state.remaining;

        unique case (state.phase)
            PH_MARKER:
            begin
                st.cur_len = '0;
                if (script_byte > MARK_LEN16)
                begin
                    tk.kind = TK_OPCODE;
                    tk.done = 1'b1;
                end
                else if (script_byte <= MAX_DIRECT)
                begin
                    // direct push, empty push completes at once
                    st.cur_len = LEN_W'(script_byte);
                    tk.plen    = LEN_W'(script_byte);
                    if (script_byte == '0)
                        tk.done = 1'b1;
                    else
                    begin
                        st.remaining = LEN_W'(script_byte);
                        st.phase     = PH_PAYLOAD;
                    end
                end
                else if (script_byte == MARK_LEN8)
                    st.phase = PH_LEN8;
                else
                begin
                    st.phase     = PH_LEN16;
                    st.remaining = LEN_W'(2);
                end
            end
            PH_LEN8:
            begin
                st.cur_len = LEN_W'(script_byte);
                tk.plen    = LEN_W'(script_byte);
                if (script_byte == '0)
                begin
                    st.phase = PH_MARKER;
                    tk.done  = 1'b1;
                end
                else
                begin
                    st.remaining = LEN_W'(script_byte);
                    st.phase     = PH_PAYLOAD;
                end
            end
            PH_LEN16:
            begin
                if (state.remaining >= LEN_W'(2))
                begin
                    st.len_low   = script_byte;
                    st.remaining = LEN_W'(1);
                end
                else
                begin
                    st.cur_len = len16;
                    tk.plen    = len16;
                    if (len16 == '0)
                    begin
                        st.phase = PH_MARKER;
                        tk.done  = 1'b1;
                    end
                    else
                    begin
                        st.remaining = len16;
                        st.phase     = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                tk.kind = TK_PAYLOAD;
                tk.plen = state.cur_len;
                if (state.remaining != '0)
                    rem_dec = state.remaining - LEN_W'(1);
                st.remaining = rem_dec;
                if (rem_dec == '0)
                begin
                    st.phase = PH_MARKER;
                    tk.done  = 1'b1;
                end
            end
            default:
            begin
                st = PARSE_RESET;
            end
        endcase

        // end of script: flag an unfinished push, then return to reset
        if (end_of_script)
        begin
            if (st.phase != PH_MARKER)
            begin
                tk.trunc = 1'b1;
                tk.done  = 1'b0;
            end
            st = PARSE_RESET;
        end
    end

    assign state_next = st;
    assign token      = tk;

endmodule

/* design/script_push_tokenizer_top.sv */
// ----------------------------------------------------------------------------
// script_push_tokenizer_top
// Byte-stream tokenizer for script push elements.
// ----------------------------------------------------------------------------
// Takes one script byte per transfer and returns exactly one token per byte:
// opcode, push header (marker or length byte) or push payload, with the
// declared push length, an element-done flag and a truncated flag when the
// script ends inside a push. Throughput is one byte per cycle while the output
// side does not stall. A token becomes valid once its byte has passed through
// both stages: the transfer loads the input register, and the classifier
// result then loads into the output register. The parser state updates when a
// byte moves from the input register into the output register, so a stall on
// the output side holds both stages without losing or repeating a byte.
// ----------------------------------------------------------------------------
module script_push_tokenizer_top (
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  script_byte,
    input  logic        end_of_script,
    // output channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  token_kind,
    output logic [7:0]  byte_value,
    output logic        element_done,
    output logic [15:0] push_length,
    output logic        truncated
);
    import spt_pkg::*;

    logic               in_valid_reg;
    logic [BYTE_W-1:0]  byte_reg;
    logic               eos_reg;
    logic               out_valid_reg;
    token_t             token_reg;
    parse_state_t       state_reg;
    parse_state_t       state_next;
    token_t             token_next;
    logic               advance;

    // stage 1 moves on when the output register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= script_byte;
            eos_reg  <= end_of_script;
        end
    end

    // classifier
    spt_decode u_decode (
        .state         (state_reg),
        .script_byte   (byte_reg),
        .end_of_script (eos_reg),
        .state_next    (state_next),
        .token         (token_next)
    );

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= PARSE_RESET;
        else if (advance)
            state_reg <= state_next;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            token_reg <= token_next;
    end

    assign out_valid    = out_valid_reg;
    assign token_kind   = token_reg.kind;
    assign byte_value   = token_reg.value;
    assign element_done = token_reg.done;
    assign push_length  = token_reg.plen;
    assign truncated    = token_reg.trunc;

endmodule
